[rtl/tcalc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcalc_pkg
// Shared types and constants for the two-operand text calculator.
// ----------------------------------------------------------------------------
package tcalc_pkg;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam int WHOLE_W = 63;
    localparam int FRAC_W  = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_BAD_OP   = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_CALC   = 3'd1,
        S_DIV    = 3'd2,
        S_DIVFIN = 3'd3,
        S_EMIT   = 3'd4
    } t_state;

    typedef struct packed {
        logic accept;
        logic calc;
        logic div_step;
        logic div_fin;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic phase;
        logic b_zero;
        logic op_div;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/tcalc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcalc_dp
// Datapath: operand accumulators, ALU, radix-2 divider and output register.
// ----------------------------------------------------------------------------
module tcalc_dp #(
    parameter int OPERAND_BITS  = 31,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [7:0]                   i_char,
    input  wire tcalc_pkg::t_dp_cmd           i_cmd,
    output tcalc_pkg::t_dp_sts                o_sts,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [tcalc_pkg::WHOLE_W-1:0]     o_out_whole,
    output logic [tcalc_pkg::FRAC_W-1:0]      o_out_frac,
    output tcalc_pkg::t_status                o_out_status
);

    localparam int OB = OPERAND_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int QW = OB + FB;
    localparam int AW = OB + 4;
    localparam logic [AW-1:0] ACC_MAX   = AW'({OB{1'b1}});
    localparam logic [QW-1:0] FRAC_MASK = (QW'(1) << FB) - QW'(1);

    logic                        r_phase;
    logic [OB-1:0]               r_a;
    logic [OB-1:0]               r_b;
    tcalc_pkg::t_op              r_op;
    logic                        r_ovf;
    logic [tcalc_pkg::WHOLE_W-1:0] r_whole;
    logic [tcalc_pkg::FRAC_W-1:0]  r_frac;
    tcalc_pkg::t_status          r_status;
    logic [QW-1:0]               r_dvd;
    logic [OB-1:0]               r_rem;
    logic                        r_out_valid;
    logic [tcalc_pkg::WHOLE_W-1:0] r_out_whole;
    logic [tcalc_pkg::FRAC_W-1:0]  r_out_frac;
    tcalc_pkg::t_status          r_out_status;

    logic                        is_digit;
    logic                        is_op;
    tcalc_pkg::t_op              dec_op;
    logic [3:0]                  digit;
    logic [OB-1:0]               acc_sel;
    logic [AW-1:0]               acc_v;
    logic                        acc_sat;
    logic [OB-1:0]               acc_new;
    logic [2*OB-1:0]             prod;
    logic [OB:0]                 rem_sh;
    logic [OB+1:0]               diff;
    logic                        q_bit;

    always_comb begin
        is_digit = (i_char >= tcalc_pkg::CH_ZERO) && (i_char <= tcalc_pkg::CH_NINE);
        digit    = 4'(i_char - tcalc_pkg::CH_ZERO);
        is_op    = 1'b1;
        dec_op   = tcalc_pkg::OP_ADD;
        case (i_char)
            tcalc_pkg::CH_PLUS:  dec_op = tcalc_pkg::OP_ADD;
            tcalc_pkg::CH_MINUS: dec_op = tcalc_pkg::OP_SUB;
            tcalc_pkg::CH_STAR:  dec_op = tcalc_pkg::OP_MUL;
            tcalc_pkg::CH_SLASH: dec_op = tcalc_pkg::OP_DIV;
            default:             is_op  = 1'b0;
        endcase
        acc_sel = r_phase ? r_b : r_a;
        acc_v   = (AW'(acc_sel) << 3) + (AW'(acc_sel) << 1) + AW'(digit);
        acc_sat = acc_v > ACC_MAX;
        acc_new = acc_sat ? {OB{1'b1}} : acc_v[OB-1:0];
        prod    = r_a * r_b;
        rem_sh  = {r_rem, r_dvd[QW-1]};
        diff    = {1'b0, rem_sh} - (OB+2)'(r_b);
        q_bit   = ~diff[OB+1];
    end

    // operand and opcode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_a     <= '0;
            r_b     <= '0;
            r_op    <= tcalc_pkg::OP_ADD;
            r_ovf   <= 1'b0;
        end else if (i_cmd.emit) begin
            r_phase <= 1'b0;
            r_a     <= '0;
            r_b     <= '0;
            r_op    <= tcalc_pkg::OP_ADD;
            r_ovf   <= 1'b0;
        end else if (i_cmd.accept) begin
            if (is_digit) begin
                if (r_phase) begin
                    r_b <= acc_new;
                end else begin
                    r_a <= acc_new;
                end
                if (acc_sat) begin
                    r_ovf <= 1'b1;
                end
            end else if (!r_phase && is_op) begin
                r_op    <= dec_op;
                r_phase <= 1'b1;
            end
        end
    end

    // result and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !is_digit && !r_phase && !is_op) begin
            r_whole  <= '0;
            r_frac   <= '0;
            r_status <= tcalc_pkg::ST_BAD_OP;
        end
        if (i_cmd.calc) begin
            r_frac   <= '0;
            r_status <= r_ovf ? tcalc_pkg::ST_OVERFLOW : tcalc_pkg::ST_OK;
            r_dvd    <= QW'(r_a) << FB;
            r_rem    <= '0;
            case (r_op)
                tcalc_pkg::OP_ADD: r_whole <= tcalc_pkg::WHOLE_W'(r_a)
                                            + tcalc_pkg::WHOLE_W'(r_b);
                tcalc_pkg::OP_SUB: r_whole <= tcalc_pkg::WHOLE_W'(r_a)
                                            - tcalc_pkg::WHOLE_W'(r_b);
                tcalc_pkg::OP_MUL: r_whole <= tcalc_pkg::WHOLE_W'(prod);
                default: begin
                    r_whole <= '0;
                    if (r_b == '0) begin
                        r_status <= tcalc_pkg::ST_DIV_ZERO;
                    end
                end
            endcase
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? diff[OB-1:0] : rem_sh[OB-1:0];
            r_dvd <= {r_dvd[QW-2:0], q_bit};
        end
        if (i_cmd.div_fin) begin
            r_whole <= tcalc_pkg::WHOLE_W'(r_dvd >> FB);
            r_frac  <= tcalc_pkg::FRAC_W'(r_dvd & FRAC_MASK);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_whole  <= r_whole;
            r_out_frac   <= r_frac;
            r_out_status <= r_status;
        end
    end

    always_comb begin
        o_sts.is_digit = is_digit;
        o_sts.is_op    = is_op;
        o_sts.phase    = r_phase;
        o_sts.b_zero   = (r_b == '0);
        o_sts.op_div   = (r_op == tcalc_pkg::OP_DIV);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_whole  = r_out_whole;
    assign o_out_frac   = r_out_frac;
    assign o_out_status = r_out_status;

endmodule
`default_nettype wire

[rtl/tcalc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcalc_ctrl
// Controller: sequences character intake, evaluation, division and output.
// ----------------------------------------------------------------------------
module tcalc_ctrl #(
    parameter int QUOT_BITS = 47
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire tcalc_pkg::t_dp_sts  i_sts,
    output tcalc_pkg::t_dp_cmd       o_cmd
);

    localparam int CNT_W = $clog2(QUOT_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_BITS - 1);

    tcalc_pkg::t_state r_state;
    tcalc_pkg::t_state n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              accept;

    assign accept = i_valid && (r_state == tcalc_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcalc_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            tcalc_pkg::S_IDLE: begin
                if (accept && !i_sts.is_digit) begin
                    if (i_sts.phase) begin
                        n_state = tcalc_pkg::S_CALC;
                    end else if (!i_sts.is_op) begin
                        n_state = tcalc_pkg::S_EMIT;
                    end
                end
            end
            tcalc_pkg::S_CALC: begin
                n_cnt = '0;
                if (i_sts.op_div && !i_sts.b_zero) begin
                    n_state = tcalc_pkg::S_DIV;
                end else begin
                    n_state = tcalc_pkg::S_EMIT;
                end
            end
            tcalc_pkg::S_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = tcalc_pkg::S_DIVFIN;
                end
            end
            tcalc_pkg::S_DIVFIN: begin
                n_state = tcalc_pkg::S_EMIT;
            end
            tcalc_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = tcalc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcalc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready        = (r_state == tcalc_pkg::S_IDLE);
        o_cmd.accept   = accept;
        o_cmd.calc     = (r_state == tcalc_pkg::S_CALC);
        o_cmd.div_step = (r_state == tcalc_pkg::S_DIV);
        o_cmd.div_fin  = (r_state == tcalc_pkg::S_DIVFIN);
        o_cmd.emit     = (r_state == tcalc_pkg::S_EMIT) && i_sts.out_free;
    end

`ifndef ASSERT_OFF
    a_term_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_sts.phase && !i_sts.is_digit |=> r_state == tcalc_pkg::S_CALC)
        else $error("terminator did not start evaluation");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tcalc_pkg::S_DIV |-> r_cnt <= CNT_LAST)
        else $error("divider step count out of range");

    a_divfin_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tcalc_pkg::S_DIVFIN |-> $past(r_state) == tcalc_pkg::S_DIV)
        else $error("division finished without stepping");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == tcalc_pkg::S_IDLE)
        else $error("emit did not return to idle");
`endif

endmodule
`default_nettype wire

[rtl/two_operand_text_calculator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_operand_text_calculator
// Infix calculator for one ASCII expression "a op b" per result.
// ----------------------------------------------------------------------------
// Characters are taken one per transaction. A digit, or the operator after
// the first operand, is absorbed in the idle state and the input stays ready
// for the next character. The character that ends an expression (or an
// invalid operator) puts out one result: an invalid operator goes straight
// to the emit state; add, subtract, multiply and division by zero pass the
// evaluation state first; divide also runs the one-bit-per-cycle restoring
// divider and its finishing state. Results sit in an output register, so
// characters are taken while a result waits; input stalls in evaluation,
// division and emit, the last until the previous result has been taken.
module two_operand_text_calculator #(
    parameter int OPERAND_BITS  = 31,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // [62:0] result_whole, [78:63] result_fraction
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    tcalc_pkg::t_dp_cmd              cmd;
    tcalc_pkg::t_dp_sts              sts;
    logic [tcalc_pkg::WHOLE_W-1:0]   out_whole;
    logic [tcalc_pkg::FRAC_W-1:0]    out_frac;
    tcalc_pkg::t_status              out_status;

    tcalc_ctrl #(
        .QUOT_BITS (OPERAND_BITS + FRACTION_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tcalc_dp #(
        .OPERAND_BITS  (OPERAND_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (s_axis_tdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_whole  (out_whole),
        .o_out_frac   (out_frac),
        .o_out_status (out_status)
    );

    assign m_axis_tdata = {1'b0, out_frac, out_whole};
    assign m_axis_tuser = out_status;

endmodule
`default_nettype wire

[tb/two_operand_text_calculator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_operand_text_calculator_tb
// Streams ASCII expressions into the calculator and checks every result.
// ----------------------------------------------------------------------------
// A short directed part covers invalid operators, empty operands, division
// with a fraction and by zero, negative differences, operand saturation and
// extreme character codes. Random expressions follow: mostly well-formed
// "a op b" text with random terminators, mixed with raw noise bytes.
// Expected results come from a local model of the calculator that is
// updated on each input transaction. Both sides idle in random bursts,
// except near the end of the run.
module two_operand_text_calculator_tb;

    localparam int OPERAND_BITS  = 31;
    localparam int FRACTION_BITS = 16;
    localparam int STIM_CHARS    = 1625;
    localparam int TAIL_CHARS    = 250;
    localparam int DRAIN_CYCLES  = 120;
    localparam int STALL_LIMIT   = 4000;
    localparam logic [OPERAND_BITS-1:0] OPND_MAX = '1;

    typedef struct packed {
        logic [tcalc_pkg::WHOLE_W-1:0] whole;
        logic [tcalc_pkg::FRAC_W-1:0]  frac;
        tcalc_pkg::t_status            status;
    } t_calc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] char_code
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;         // [62:0] result_whole, [78:63] result_fraction
    logic [1:0]  m_axis_tuser;         // [1:0] status

    logic [7:0]   char_q[$];
    t_calc_result pending_results[$];
    t_calc_result want;
    int           mismatches = 0;
    int           send_gap = 0;
    int           recv_hold = 0;
    int           gap_pct = 0;
    int           quiet_cycles = 0;
    logic [6:0]   cyc = '0;

    // expression state
    logic                    in_second = 1'b0;
    logic [OPERAND_BITS-1:0] opnd_a = '0;
    logic [OPERAND_BITS-1:0] opnd_b = '0;
    tcalc_pkg::t_op          op_sel = tcalc_pkg::OP_ADD;
    logic                    sat_flag = 1'b0;

    two_operand_text_calculator #(
        .OPERAND_BITS  (OPERAND_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // returns {saturated, new operand}
    function automatic logic [OPERAND_BITS:0] scale_in(input logic [OPERAND_BITS-1:0] acc,
                                                       input logic [7:0] c);
        logic [63:0] v;
        v = 64'(acc) * 64'd10 + 64'(c - tcalc_pkg::CH_ZERO);
        if (v > 64'(OPND_MAX)) begin
            return {1'b1, OPND_MAX};
        end
        return {1'b0, v[OPERAND_BITS-1:0]};
    endfunction

    task automatic clear_expr();
        in_second = 1'b0;
        opnd_a    = '0;
        opnd_b    = '0;
        op_sel    = tcalc_pkg::OP_ADD;
        sat_flag  = 1'b0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        logic [63:0]        a;
        logic [63:0]        b;
        logic [63:0]        whole;
        logic [63:0]        frac;
        logic               ovf;
        logic               is_dig;
        tcalc_pkg::t_status st;
        is_dig = (c >= tcalc_pkg::CH_ZERO) && (c <= tcalc_pkg::CH_NINE);
        if (!in_second) begin
            if (is_dig) begin
                {ovf, opnd_a} = scale_in(opnd_a, c);
                sat_flag = sat_flag | ovf;
            end else if (c == tcalc_pkg::CH_PLUS) begin
                op_sel = tcalc_pkg::OP_ADD;
                in_second = 1'b1;
            end else if (c == tcalc_pkg::CH_MINUS) begin
                op_sel = tcalc_pkg::OP_SUB;
                in_second = 1'b1;
            end else if (c == tcalc_pkg::CH_STAR) begin
                op_sel = tcalc_pkg::OP_MUL;
                in_second = 1'b1;
            end else if (c == tcalc_pkg::CH_SLASH) begin
                op_sel = tcalc_pkg::OP_DIV;
                in_second = 1'b1;
            end else begin
                pending_results.push_back('{whole: '0, frac: '0,
                                            status: tcalc_pkg::ST_BAD_OP});
                clear_expr();
            end
        end else if (is_dig) begin
            {ovf, opnd_b} = scale_in(opnd_b, c);
            sat_flag = sat_flag | ovf;
        end else begin
            a     = 64'(opnd_a);
            b     = 64'(opnd_b);
            whole = '0;
            frac  = '0;
            st    = sat_flag ? tcalc_pkg::ST_OVERFLOW : tcalc_pkg::ST_OK;
            case (op_sel)
                tcalc_pkg::OP_ADD: whole = a + b;
                tcalc_pkg::OP_SUB: whole = a - b;
                tcalc_pkg::OP_MUL: whole = a * b;
                default: begin
                    if (b == 0) begin
                        st = tcalc_pkg::ST_DIV_ZERO;
                    end else begin
                        whole = a / b;
                        frac  = ((a % b) << FRACTION_BITS) / b;
                    end
                end
            endcase
            pending_results.push_back('{whole: whole[tcalc_pkg::WHOLE_W-1:0],
                                        frac: frac[tcalc_pkg::FRAC_W-1:0], status: st});
            clear_expr();
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            char_q.push_back(s[i]);
        end
    endtask

    task automatic push_operand();
        int n;
        case ($urandom_range(0, 9))
            0:             n = 0;
            1, 2, 3, 4, 5: n = $urandom_range(1, 3);
            6, 7, 8:       n = $urandom_range(4, 9);
            default:       n = $urandom_range(10, 12);
        endcase
        if (n == 10 && $urandom_range(0, 1) == 1) begin
            push_text($urandom_range(0, 1) == 1 ? "2147483647" : "2147483648");
        end else begin
            repeat (n) char_q.push_back(
                8'($urandom_range(tcalc_pkg::CH_ZERO, tcalc_pkg::CH_NINE)));
        end
    endtask

    task automatic push_terminator();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c >= tcalc_pkg::CH_ZERO && c <= tcalc_pkg::CH_NINE);
        char_q.push_back(c);
    endtask

    // idle density is redrawn each time the cycle counter wraps, zero included
    always @(posedge i_clk) begin
        cyc <= cyc + 7'd1;
        if (cyc == '0) begin
            case ($urandom_range(0, 3))
                0:       gap_pct <= 0;
                1:       gap_pct <= 8;
                2:       gap_pct <= 25;
                default: gap_pct <= 50;
            endcase
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (char_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= char_q.pop_front();
                if (char_q.size() >= TAIL_CHARS && $urandom_range(0, 99) < gap_pct) begin
                    send_gap <= $urandom_range(1, 5);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_hold     <= 0;
        end else if (recv_hold != 0) begin
            m_axis_tready <= 1'b0;
            recv_hold     <= recv_hold - 1;
        end else if (char_q.size() >= TAIL_CHARS && $urandom_range(0, 99) < gap_pct) begin
            m_axis_tready <= 1'b0;
            recv_hold     <= $urandom_range(0, 4);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_char(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result whole=%0d frac=%0d status=%0d", $time,
                             $signed(m_axis_tdata[62:0]), m_axis_tdata[78:63], m_axis_tuser);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[62:0] !== want.whole) begin
                        $display("%0t: result_whole expected %0d, got %0d", $time,
                                 $signed(want.whole), $signed(m_axis_tdata[62:0]));
                        mismatches++;
                    end
                    if (m_axis_tdata[78:63] !== want.frac) begin
                        $display("%0t: result_fraction expected %0d, got %0d", $time,
                                 want.frac, m_axis_tdata[78:63]);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 want.status, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // directed
        char_q.push_back(8'h00);
        push_text("7/2");
        char_q.push_back(8'hFF);
        push_text("/0:");
        push_text("-5=");
        push_text("2147483648++");
        push_text("3*4 ");
        // random
        while (char_q.size() < STIM_CHARS) begin
            if ($urandom_range(0, 99) < 85) begin
                push_operand();
                case ($urandom_range(0, 3))
                    0:       char_q.push_back(tcalc_pkg::CH_PLUS);
                    1:       char_q.push_back(tcalc_pkg::CH_MINUS);
                    2:       char_q.push_back(tcalc_pkg::CH_STAR);
                    default: char_q.push_back(tcalc_pkg::CH_SLASH);
                endcase
                push_operand();
                push_terminator();
            end else begin
                char_q.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tcalc_pkg.sv
rtl/tcalc_dp.sv
rtl/tcalc_ctrl.sv
rtl/two_operand_text_calculator.sv
tb/two_operand_text_calculator_tb.sv
